/* src/olr_pkg.sv */
// Shared types and constants of the overwriting log ring.
// Used by olr_front, olr_queue, olr_back and overwriting_log_ring.
package olr_pkg;

  localparam int unsigned RingBytesDef = 64 * 1024;
  localparam int unsigned MaxRecordDef = 4 * 1024;
  localparam int unsigned ReadersDef   = 4;
  localparam int unsigned HdrBytes     = 20;

  localparam logic [2:0] OP_BEGIN   = 3'd0;
  localparam logic [2:0] OP_PAYLOAD = 3'd1;
  localparam logic [2:0] OP_READ    = 3'd2;
  localparam logic [2:0] OP_OPEN    = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;
  localparam logic [2:0] OP_QUERY   = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;
  localparam logic [1:0] ST_BUSY    = 2'd3;

  // K_IGNORE is dropped unconditionally; K_DROP only when no payload is pending
  typedef enum logic [2:0] {
    K_BEGIN, K_PAYLOAD, K_READ, K_OPEN, K_FLUSH, K_QUERY, K_IGNORE, K_DROP
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  rid;
    logic [7:0]  data;
    logic [15:0] len;
    logic [31:0] tag_process;
    logic [31:0] tag_thread;
    logic [31:0] tag_seconds;
    logic [31:0] tag_nanoseconds;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(cmd_t c, logic [4:0] idx);
    logic [159:0] h;
    h = {c.tag_nanoseconds, c.tag_seconds, c.tag_thread, c.tag_process, 16'h0000, c.len};
    return h[{idx, 3'b000} +: 8];
  endfunction

endpackage

/* src/overwriting_log_ring.sv */
// Overwriting log ring: variable-length records in a byte ring, four readers.
// Results are registered; a read or query at a record boundary first fetches
// the two length bytes of the record there.
// Begin entry: checks each pointer, walks a lapped pointer record by record,
// then writes the 20 header bytes; one ring port sets this.
// The sequencer takes a new word only after the last result has been taken.
// Reset is asynchronous, active low; pointers clear, ring contents do not.
module overwriting_log_ring #(
  parameter int unsigned RING_BYTES       = olr_pkg::RingBytesDef,
  parameter int unsigned MAX_RECORD_BYTES = olr_pkg::MaxRecordDef,
  parameter int unsigned READERS          = olr_pkg::ReadersDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [1:0]  reader_id_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] entry_len_i,
  input  logic [31:0] tag_process_i,
  input  logic [31:0] tag_thread_i,
  input  logic [31:0] tag_seconds_i,
  input  logic [31:0] tag_nanoseconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  read_data_o,
  output logic        record_last_o,
  output logic        reader_was_lapped_o,
  output logic [15:0] used_bytes_o,
  output logic [12:0] next_record_bytes_o
);

  olr_pkg::cmd_t f_cmd, q_cmd;
  logic          push, q_ready, q_valid, pop;

  olr_front #(.MAX_RECORD_BYTES(MAX_RECORD_BYTES), .READERS(READERS)) u_front (
    .in_valid_i, .in_ready_o, .op_i, .reader_id_i, .data_byte_i, .entry_len_i,
    .tag_process_i, .tag_thread_i, .tag_seconds_i, .tag_nanoseconds_i,
    .q_ready_i(q_ready), .push_o(push), .cmd_o(f_cmd)
  );

  olr_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(f_cmd), .ready_o(q_ready),
    .valid_o(q_valid), .pop_i(pop), .cmd_o(q_cmd)
  );

  olr_back #(
    .RING_BYTES(RING_BYTES), .MAX_RECORD_BYTES(MAX_RECORD_BYTES), .READERS(READERS)
  ) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(q_valid), .cmd_i(q_cmd), .cmd_pop_o(pop),
    .out_valid_o, .out_ready_i, .status_o, .read_data_o, .record_last_o,
    .reader_was_lapped_o, .used_bytes_o, .next_record_bytes_o
  );

endmodule

/* src/olr_front.sv */
// Front end: takes input words, classifies them and clamps the entry length.
// Depends on olr_pkg.
module olr_front #(
  parameter int unsigned MAX_RECORD_BYTES = olr_pkg::MaxRecordDef,
  parameter int unsigned READERS          = olr_pkg::ReadersDef
) (
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        op_i,
  input  logic [1:0]        reader_id_i,
  input  logic [7:0]        data_byte_i,
  input  logic [15:0]       entry_len_i,
  input  logic [31:0]       tag_process_i,
  input  logic [31:0]       tag_thread_i,
  input  logic [31:0]       tag_seconds_i,
  input  logic [31:0]       tag_nanoseconds_i,
  input  logic              q_ready_i,
  output logic              push_o,
  output olr_pkg::cmd_t     cmd_o
);

  localparam int unsigned MaxPayload = MAX_RECORD_BYTES - olr_pkg::HdrBytes;

  logic [15:0] len_clamped;
  logic        rid_ok;

  always_comb begin
    if ({1'b0, entry_len_i} > 17'(MaxPayload)) begin
      len_clamped = 16'(MaxPayload);
    end else begin
      len_clamped = entry_len_i;
    end
    rid_ok = 5'(reader_id_i) < 5'(READERS);

    cmd_o.rid             = reader_id_i;
    cmd_o.data            = data_byte_i;
    cmd_o.len             = len_clamped;
    cmd_o.tag_process     = tag_process_i;
    cmd_o.tag_thread      = tag_thread_i;
    cmd_o.tag_seconds     = tag_seconds_i;
    cmd_o.tag_nanoseconds = tag_nanoseconds_i;
    case (op_i)
      olr_pkg::OP_BEGIN:   cmd_o.kind = (len_clamped == 16'd0) ? olr_pkg::K_DROP
                                                               : olr_pkg::K_BEGIN;
      olr_pkg::OP_PAYLOAD: cmd_o.kind = olr_pkg::K_PAYLOAD;
      olr_pkg::OP_READ:    cmd_o.kind = rid_ok ? olr_pkg::K_READ : olr_pkg::K_DROP;
      olr_pkg::OP_OPEN:    cmd_o.kind = rid_ok ? olr_pkg::K_OPEN : olr_pkg::K_DROP;
      olr_pkg::OP_FLUSH:   cmd_o.kind = olr_pkg::K_FLUSH;
      olr_pkg::OP_QUERY:   cmd_o.kind = rid_ok ? olr_pkg::K_QUERY : olr_pkg::K_DROP;
      default:             cmd_o.kind = olr_pkg::K_IGNORE;
    endcase
  end

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i & q_ready_i;

endmodule

/* src/olr_queue.sv */
// Two-entry command queue between front and back end.
// Depends on olr_pkg.
module olr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  olr_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          pop_i,
  output olr_pkg::cmd_t cmd_o
);

  olr_pkg::cmd_t ent_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign cmd_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wp_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* src/olr_back.sv */
// Back end: ring memory, pointers and the sequencer that runs each command.
// Depends on olr_pkg.
module olr_back #(
  parameter int unsigned RING_BYTES       = olr_pkg::RingBytesDef,
  parameter int unsigned MAX_RECORD_BYTES = olr_pkg::MaxRecordDef,
  parameter int unsigned READERS          = olr_pkg::ReadersDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  olr_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    status_o,
  output logic [7:0]    read_data_o,
  output logic          record_last_o,
  output logic          reader_was_lapped_o,
  output logic [15:0]   used_bytes_o,
  output logic [12:0]   next_record_bytes_o
);

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned LW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned PW = $clog2(MAX_RECORD_BYTES);
  localparam int unsigned RW = (READERS > 1) ? $clog2(READERS) : 1;
  localparam int unsigned TW = $clog2(READERS + 1);
  localparam int unsigned SW = 17;
  localparam int unsigned CW = 18;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FMID = 3'd1;
  localparam logic [2:0] S_FHI  = 3'd2;
  localparam logic [2:0] S_TCHK = 3'd3;
  localparam logic [2:0] S_WMID = 3'd4;
  localparam logic [2:0] S_WHI  = 3'd5;
  localparam logic [2:0] S_HDR  = 3'd6;

  function automatic logic in_span(logic [AW-1:0] a, logic [AW-1:0] b, logic [AW-1:0] c);
    if (a < b) return (a < c) && (c <= b);
    return (c <= b) || (a < c);
  endfunction

  logic [7:0]    mem [RING_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  logic [2:0]    st_q, st_d;
  olr_pkg::cmd_t cmd_q, cmd_d, c;
  logic [AW-1:0] wr_q, wr_d, head_q, head_d;
  logic [AW-1:0] roff_q [READERS];
  logic [AW-1:0] roff_d [READERS];
  logic [AW-1:0] rstart_q [READERS];
  logic [AW-1:0] rstart_d [READERS];
  logic [LW-1:0] rleft_q [READERS];
  logic [LW-1:0] rleft_d [READERS];
  logic [READERS-1:0] rlap_q, rlap_d;
  logic [PW-1:0] pend_q, pend_d;
  logic [TW-1:0] tgt_q, tgt_d;
  logic [AW-1:0] woff_q, woff_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [7:0]    lo_q, lo_d;
  logic [4:0]    hcnt_q, hcnt_d;

  logic          ov_q;
  logic          fin;
  logic [1:0]    fstat;
  logic [7:0]    fdata;
  logic          flast, flap;
  logic [15:0]   fused;
  logic [12:0]   fnext;

  logic [RW-1:0] ridx, tidx;
  logic          is_head;
  logic [AW-1:0] tstart, nw, diff, noff;
  logic [SW-1:0] total, rsize;
  logic [CW-1:0] ncnt;

  assign cmd_pop_o = (st_q == S_IDLE) && cmd_valid_i && !ov_q;
  assign c         = (st_q == S_IDLE) ? cmd_i : cmd_q;
  assign ridx      = RW'(c.rid);
  assign tidx      = tgt_q[RW-1:0];
  assign is_head   = tgt_q == TW'(READERS);
  assign total     = SW'(olr_pkg::HdrBytes) + SW'(cmd_q.len);
  assign nw        = wr_q + AW'(total);
  assign rsize     = SW'(olr_pkg::HdrBytes) + SW'({mem_q, lo_q});
  assign diff      = wr_q - roff_q[ridx];
  assign noff      = woff_q + AW'(rsize);
  assign ncnt      = cnt_q + CW'(rsize);
  assign tstart    = is_head ? head_q
                   : ((rleft_q[tidx] != '0) ? rstart_q[tidx] : roff_q[tidx]);

  always_comb begin
    st_d = st_q; cmd_d = cmd_q; wr_d = wr_q; head_d = head_q;
    roff_d = roff_q; rstart_d = rstart_q; rleft_d = rleft_q; rlap_d = rlap_q;
    pend_d = pend_q; tgt_d = tgt_q; woff_d = woff_q; cnt_d = cnt_q;
    lo_d = lo_q; hcnt_d = hcnt_q;
    mem_we = 1'b0; mem_addr = roff_q[ridx]; mem_wdata = c.data;
    fin = 1'b0; fstat = olr_pkg::ST_OK; fdata = 8'd0; flast = 1'b0;
    flap = 1'b0; fused = 16'd0; fnext = 13'd0;

    case (st_q)
      S_IDLE: begin
        if (cmd_pop_o) begin
          cmd_d = cmd_i;
          if (c.kind == olr_pkg::K_IGNORE) begin
            fin = 1'b1; fstat = olr_pkg::ST_IGNORED;
          end else if (c.kind == olr_pkg::K_PAYLOAD) begin
            fin = 1'b1;
            if (pend_q == '0) begin
              fstat = olr_pkg::ST_IGNORED;
            end else begin
              mem_we = 1'b1; mem_addr = wr_q;
              wr_d = wr_q + 1'b1; pend_d = pend_q - 1'b1;
            end
          end else if (pend_q != '0) begin
            fin = 1'b1; fstat = olr_pkg::ST_BUSY;
          end else begin
            case (c.kind)
              olr_pkg::K_FLUSH: begin
                for (int i = 0; i < READERS; i++) begin
                  roff_d[i] = wr_q; rstart_d[i] = wr_q; rleft_d[i] = '0;
                end
                head_d = wr_q; fin = 1'b1;
              end
              olr_pkg::K_OPEN: begin
                roff_d[ridx] = head_q; rstart_d[ridx] = head_q;
                rleft_d[ridx] = '0; rlap_d[ridx] = 1'b0; fin = 1'b1;
              end
              olr_pkg::K_READ: begin
                if (rleft_q[ridx] == '0 && roff_q[ridx] == wr_q) begin
                  fin = 1'b1; fstat = olr_pkg::ST_EMPTY;
                  flap = rlap_q[ridx]; rlap_d[ridx] = 1'b0;
                end else begin
                  st_d = S_FMID;
                end
              end
              olr_pkg::K_QUERY: begin
                if (rleft_q[ridx] != '0 || roff_q[ridx] == wr_q) begin
                  fin = 1'b1; flap = rlap_q[ridx]; fused = 16'(diff);
                  fnext = 13'(rleft_q[ridx]);
                end else begin
                  st_d = S_FMID;
                end
              end
              olr_pkg::K_BEGIN: begin
                tgt_d = '0; st_d = S_TCHK;
              end
              default: begin
                fin = 1'b1; fstat = olr_pkg::ST_IGNORED;
              end
            endcase
          end
        end
      end
      S_FMID: begin
        lo_d = mem_q;
        if (c.kind == olr_pkg::K_READ && rleft_q[ridx] != '0) begin
          fin = 1'b1; fdata = mem_q; flap = rlap_q[ridx]; rlap_d[ridx] = 1'b0;
          rleft_d[ridx] = rleft_q[ridx] - 1'b1;
          flast = rleft_q[ridx] == LW'(1);
          roff_d[ridx] = roff_q[ridx] + 1'b1;
          st_d = S_IDLE;
        end else begin
          mem_addr = roff_q[ridx] + 1'b1;
          st_d = S_FHI;
        end
      end
      S_FHI: begin
        fin = 1'b1; flap = rlap_q[ridx]; st_d = S_IDLE;
        if (c.kind == olr_pkg::K_READ) begin
          fdata = lo_q; rlap_d[ridx] = 1'b0;
          rstart_d[ridx] = roff_q[ridx];
          rleft_d[ridx] = LW'(rsize - 1'b1);
          flast = rsize == SW'(1);
          roff_d[ridx] = roff_q[ridx] + 1'b1;
        end else begin
          fused = 16'(diff); fnext = 13'(rsize);
        end
      end
      S_TCHK: begin
        if (in_span(wr_q, nw, tstart)) begin
          woff_d = tstart; cnt_d = '0; mem_addr = tstart; st_d = S_WMID;
        end else if (is_head) begin
          hcnt_d = '0; st_d = S_HDR;
        end else begin
          tgt_d = tgt_q + 1'b1;
        end
      end
      S_WMID: begin
        lo_d = mem_q; mem_addr = woff_q + 1'b1; st_d = S_WHI;
      end
      S_WHI: begin
        if (ncnt >= CW'(total)) begin
          // pull the pointer to the first boundary past the new end
          if (is_head) begin
            head_d = noff; hcnt_d = '0; st_d = S_HDR;
          end else begin
            roff_d[tidx] = noff; rstart_d[tidx] = noff;
            rleft_d[tidx] = '0; rlap_d[tidx] = 1'b1;
            tgt_d = tgt_q + 1'b1; st_d = S_TCHK;
          end
        end else begin
          woff_d = noff; cnt_d = ncnt; mem_addr = noff; st_d = S_WMID;
        end
      end
      S_HDR: begin
        mem_we = 1'b1; mem_addr = wr_q;
        mem_wdata = olr_pkg::hdr_byte(cmd_q, hcnt_q);
        wr_d = wr_q + 1'b1; hcnt_d = hcnt_q + 1'b1;
        if (hcnt_q == 5'(olr_pkg::HdrBytes - 1)) begin
          fin = 1'b1; pend_d = PW'(cmd_q.len); st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    woff_q <= woff_d;
    cnt_q  <= cnt_d;
    lo_q   <= lo_d;
    if (fin) begin
      status_o            <= fstat;
      read_data_o         <= fdata;
      record_last_o       <= flast;
      reader_was_lapped_o <= flap;
      used_bytes_o        <= fused;
      next_record_bytes_o <= fnext;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      wr_q   <= '0;
      head_q <= '0;
      for (int i = 0; i < READERS; i++) begin
        roff_q[i] <= '0; rstart_q[i] <= '0; rleft_q[i] <= '0;
      end
      rlap_q <= '0;
      pend_q <= '0;
      tgt_q  <= '0;
      hcnt_q <= '0;
      ov_q   <= 1'b0;
    end else begin
      st_q     <= st_d;
      wr_q     <= wr_d;
      head_q   <= head_d;
      roff_q   <= roff_d;
      rstart_q <= rstart_d;
      rleft_q  <= rleft_d;
      rlap_q   <= rlap_d;
      pend_q   <= pend_d;
      tgt_q    <= tgt_d;
      hcnt_q   <= hcnt_d;
      if (fin) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = ov_q;

  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != '0 |-> st_q == S_IDLE) else $error("payload pending outside idle");
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (st_q == S_IDLE || st_q == S_HDR)) else $error("ring write in walk");
  a_hdr_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_HDR |=> wr_q == AW'($past(wr_q) + 1'b1)) else $error("header write skipped");
  a_busy_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != S_IDLE |-> !ov_q) else $error("sequencer busy while result waits");

endmodule
